### rtl/boxds_pkg.sv
// Shared types and constants for the box-average downsampler.
`timescale 1ns / 1ps

package boxds_pkg;

    localparam int PIXEL_W      = 8;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 12;
    localparam int POWER_REG_W  = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOWN_POWER   = 2'd2;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd320;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd240;
    localparam logic [POWER_REG_W-1:0]  POWER_RESET  = 2'd0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [PIXEL_W-1:0] average;
        logic               frame_last;
    } t_result;

endpackage

### rtl/boxds_out_queue.sv
// Small result queue that decouples the sum pipeline from output back-pressure.
`timescale 1ns / 1ps

module boxds_out_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  boxds_pkg::t_result                  i_data,
    output logic [boxds_pkg::QUEUE_CNT_W-1:0]   o_count,
    output logic                                o_valid,
    input  logic                                i_stall,
    output boxds_pkg::t_result                  o_data
);
    import boxds_pkg::*;

    t_result                r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   pop;

    assign pop     = (r_count != '0) && !i_stall;
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            r_count <= r_count + QUEUE_CNT_W'(i_push) - QUEUE_CNT_W'(pop);
        end
    end

    // payload slots, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |-> (r_count < QUEUE_CNT_W'(QUEUE_DEPTH)))
        else $error("result queue overflow");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_rd_ptr == r_wr_ptr))
        else $error("empty queue with pointers apart");

endmodule

### rtl/box_average_downsampler.sv
// Top level of the power-of-two box-average downsampler.
`timescale 1ns / 1ps

// Takes one 8-bit pixel per clock in raster order and emits the truncated mean of each
// 2^p by 2^p window (the pixel itself at p = 0), with o_frame_last on the final result of
// a frame. Sustained rate is one pixel per cycle while o_stall is low. Partial window sums
// live in a single-port-write, registered-read memory of MAX_WIDTH/2 entries, one per
// output column: the pixel's column entry is read on acceptance and the updated sum
// written back in the cycle after, with a forwarding register covering an entry read in
// the same cycle it is written. The first pixel of each window overwrites its entry, so
// the memory needs no clearing pass after reset. A four-entry result queue parts the
// pipeline from output back-pressure; o_stall rises once that queue and the in-flight
// result would leave at most one entry free. Configuration writes are always taken
// (o_cfg_ready is tied high) and should be made between frames.
module box_average_downsampler #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_POWER = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel transaction in
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [boxds_pkg::PIXEL_W-1:0]       i_pixel,
    // result transaction out
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [boxds_pkg::PIXEL_W-1:0]       o_average,
    output logic                                o_frame_last,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [boxds_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [boxds_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import boxds_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);          // effective width
    localparam int CW    = $clog2(MAX_WIDTH);              // column counter
    localparam int CMPW  = ((WW > WIDTH_REG_W) ? WW : WIDTH_REG_W) + 1;
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(MAX_POWER + 1);
    localparam int SW    = PIXEL_W + 2 * MAX_POWER;        // window sum
    localparam int YW    = HEIGHT_REG_W + 1;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [IW-1:0]      idx;
        logic [PW-1:0]      power;
        logic               first;
        logic               wr;
        logic               emit;
        logic               last;
    } t_stage;

    // configuration registers
    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    logic [POWER_REG_W-1:0]  r_power;

    // raster position
    logic [CW-1:0]           r_col;
    logic [HEIGHT_REG_W-1:0] r_row;

    // sum memory and its read/write side
    logic [SW-1:0] r_sums [DEPTH];
    logic [SW-1:0] r_rd_data;
    logic [SW-1:0] r_wr_sum;
    logic          r_fwd;

    // read-modify-write stage
    logic   r_v1;
    t_stage r_s1;

    // stage-0 decode
    logic [WW-1:0]           w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic [PW-1:0]           p_eff;
    logic [CW-1:0]           mask_x;
    logic [HEIGHT_REG_W-1:0] mask_y;
    logic [WW-1:0]           wfull;
    logic [HEIGHT_REG_W-1:0] hfull;
    logic [WW-1:0]           x_inc;
    logic [YW-1:0]           y_inc;
    logic                    in_win;
    logic                    accept;
    t_stage                  s0;

    // stage-1 datapath
    logic [SW-1:0]          base;
    logic [SW-1:0]          sum;
    logic                   push;
    t_result                res;
    logic [QUEUE_CNT_W-1:0] q_count;
    t_result                q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_power  <= POWER_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                CFG_DOWN_POWER:   r_power  <= i_cfg_data[POWER_REG_W-1:0];
                default: ;  // unmapped index: drop
            endcase
        end
    end

    // Clamp the registers into the range the datapath handles: zero sizes act as one,
    // the width saturates at MAX_WIDTH and the power at MAX_POWER.
    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (CMPW'(r_width) > CMPW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        h_eff = (r_height == '0) ? HEIGHT_REG_W'(1) : r_height;
        if (32'(r_power) > MAX_POWER) begin
            p_eff = PW'(MAX_POWER);
        end else begin
            p_eff = PW'(r_power);
        end
    end

    always_comb begin
        mask_x = CW'((32'd1 << p_eff) - 32'd1);
        mask_y = HEIGHT_REG_W'((32'd1 << p_eff) - 32'd1);
        wfull  = (w_eff >> p_eff) << p_eff;
        hfull  = (h_eff >> p_eff) << p_eff;
        x_inc  = WW'(r_col) + WW'(1);
        y_inc  = YW'(r_row) + YW'(1);
        in_win = (WW'(r_col) < wfull) && (r_row < hfull);

        s0.pixel = i_pixel;
        s0.idx   = IW'(r_col >> p_eff);
        s0.power = p_eff;
        s0.first = ((r_col & mask_x) == '0) && ((r_row & mask_y) == '0);
        s0.wr    = (p_eff != '0) && in_win;
        if (p_eff == '0) begin
            s0.emit = 1'b1;
            s0.last = (x_inc >= w_eff) && (y_inc >= YW'(h_eff));
        end else begin
            s0.emit = in_win && ((r_col & mask_x) == mask_x) && ((r_row & mask_y) == mask_y);
            s0.last = (x_inc == wfull) && (y_inc == YW'(hfull));
        end
    end

    // Hold new pixels once the queue plus the result in flight would leave at most one entry free.
    assign push    = r_v1 && r_s1.emit;
    assign o_stall = (q_count + QUEUE_CNT_W'(push)) >= QUEUE_CNT_W'(QUEUE_DEPTH - 1);
    assign accept  = i_valid && !o_stall;

    // Advance the raster position; wrap the column at the width and the row at the height.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (x_inc >= w_eff) begin
                r_col <= '0;
                r_row <= (y_inc >= YW'(h_eff)) ? '0 : y_inc[HEIGHT_REG_W-1:0];
            end else begin
                r_col <= x_inc[CW-1:0];
            end
        end
    end

    // Forward when the entry being read is the one stage 1 writes on this same edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_fwd <= 1'b0;
        end else begin
            r_v1 <= accept;
            if (accept) begin
                r_fwd <= r_v1 && r_s1.wr && (r_s1.idx == s0.idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= s0;
        end
    end

    // Sum memory: read on acceptance, write back from stage 1.
    always_ff @(posedge i_clk) begin
        if (r_v1 && r_s1.wr) begin
            r_sums[r_s1.idx] <= sum;
            r_wr_sum         <= sum;
        end
        if (accept) begin
            r_rd_data <= r_sums[s0.idx];
        end
    end

    // The first pixel of a window restarts the sum; the rest add on.
    always_comb begin
        base = r_fwd ? r_wr_sum : r_rd_data;
        sum  = r_s1.first ? SW'(r_s1.pixel) : base + SW'(r_s1.pixel);
        if (r_s1.power == '0) begin
            res.average = r_s1.pixel;
        end else begin
            res.average = PIXEL_W'(sum >> {r_s1.power, 1'b0});
        end
        res.frame_last = r_s1.last;
    end

    boxds_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_count (q_count),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (q_data)
    );

    assign o_average    = q_data.average;
    assign o_frame_last = q_data.frame_last;

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_fwd) |-> $past(r_v1 && r_s1.wr))
        else $error("forwarded sum without a preceding write");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_s1.last) |-> r_s1.emit)
        else $error("frame end flagged on a pixel with no result");

    a_pass_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_s1.wr) |-> (r_s1.power != '0))
        else $error("sum memory written in pass-through");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count + QUEUE_CNT_W'(push)) <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result in flight with no queue room");

endmodule

### dv/tb.sv
// Self-checking testbench for the power-of-two box-average downsampler.
`timescale 1ns / 1ps

module tb;
    import boxds_pkg::*;

    localparam int MAX_WIDTH       = 1024;
    localparam int MAX_POWER       = 3;
    localparam int SUM_ENTRIES     = MAX_WIDTH / 2;
    localparam int SUM_W           = PIXEL_W + 2 * MAX_POWER;
    localparam int TOTAL_ITEMS     = 1650;  // pixels sent over the whole run
    localparam int RANDOM_END      = 240;   // pixels sent when the random part stops
    localparam int SETTLE_CYCLES   = 16;   // pipeline drain plus margin
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int MAX_CYCLES      = 2_000_000;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    // Pixel content styles for a phase.
    typedef enum int {STYLE_WHITE, STYLE_BLACK, STYLE_BRIGHT, STYLE_UNIFORM} t_pixel_style;

    typedef enum bit {STEP_PIXEL, STEP_WRITE} t_step_kind;

    typedef struct {
        t_step_kind              kind;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0]   reg_data;
        logic [PIXEL_W-1:0]      pixel;
        bit                      typed;
        t_result                 want;
    } t_step;

    // ------------------------------------------------------------------
    // Block ports; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic                   o_stall;
    logic [PIXEL_W-1:0]     i_pixel     = '0;
    logic                   o_valid;
    logic                   i_stall     = 1'b0;
    logic [PIXEL_W-1:0]     o_average;
    logic                   o_frame_last;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    box_average_downsampler #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_POWER (MAX_POWER)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel      (i_pixel),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_average    (o_average),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: registers, band sums and raster position.
    // ------------------------------------------------------------------
    logic [WIDTH_REG_W-1:0]  cur_width  = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] cur_height = HEIGHT_RESET;
    logic [POWER_REG_W-1:0]  cur_power  = POWER_RESET;
    logic [SUM_W-1:0]        band_sums [SUM_ENTRIES];
    int unsigned             col_pos = 0;
    int unsigned             row_pos = 0;

    t_result                 pending_averages [$];

    int unsigned             sent_items      = 0;  // pixel transactions completed
    int unsigned             error_count     = 0;
    int unsigned             cycle_count     = 0;
    int unsigned             tx_idle_pct     = 0;
    int unsigned             rx_idle_pct     = 0;
    bit                      hold_off_req    = 1'b0;
    t_pixel_style            pixel_style     = STYLE_UNIFORM;

    // Directed stimulus. Typed expectations only where the value is obvious;
    // the remaining rows are left to the predictor.
    t_step directed_steps [37] = '{
        // reset geometry 320x240, pass through
        '{STEP_PIXEL, '0, '0, 8'h00, 1'b1, '{8'h00, 1'b0}},
        '{STEP_PIXEL, '0, '0, 8'hFF, 1'b1, '{8'hFF, 1'b0}},
        // shrink the width mid-frame: column 2 sits at the new width and wraps
        '{STEP_WRITE, CFG_FRAME_WIDTH,  12'd2, 8'h00, 1'b0, '0},
        '{STEP_WRITE, CFG_FRAME_HEIGHT, 12'd2, 8'h00, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'h81, 1'b1, '{8'h81, 1'b0}},
        '{STEP_PIXEL, '0, '0, 8'h7E, 1'b1, '{8'h7E, 1'b0}},
        '{STEP_PIXEL, '0, '0, 8'hCC, 1'b1, '{8'hCC, 1'b1}},
        // 4x2 frame, 2x2 windows
        '{STEP_WRITE, CFG_DOWN_POWER,   12'd1, 8'h00, 1'b0, '0},
        '{STEP_WRITE, CFG_FRAME_WIDTH,  12'd4, 8'h00, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'h00, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'h01, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'hFF, 1'b1, '{8'hFF, 1'b0}},
        '{STEP_PIXEL, '0, '0, 8'h02, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'h03, 1'b0, '0},
        // 3x3 frame: last column and last row fall outside any whole window
        '{STEP_WRITE, CFG_FRAME_WIDTH,  12'd3, 8'h00, 1'b0, '0},
        '{STEP_WRITE, CFG_FRAME_HEIGHT, 12'd3, 8'h00, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'h10, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'h20, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'h30, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'h41, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'hFF, 1'b0, '0},
        // 3x1 frame is smaller than one window: no result at all
        '{STEP_WRITE, CFG_FRAME_HEIGHT, 12'd1, 8'h00, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'h00, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'h80, 1'b0, '0},
        // zero width and height count as one: every pixel closes a frame
        '{STEP_WRITE, CFG_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, '0},
        '{STEP_WRITE, CFG_FRAME_HEIGHT, 12'd0, 8'h00, 1'b0, '0},
        '{STEP_WRITE, CFG_DOWN_POWER,   12'd0, 8'h00, 1'b0, '0},
        '{STEP_PIXEL, '0, '0, 8'h10, 1'b1, '{8'h10, 1'b1}},
        '{STEP_PIXEL, '0, '0, 8'hEF, 1'b1, '{8'hEF, 1'b1}}
    };

    // ------------------------------------------------------------------
    // Predictor: take one pixel, update the band sums and the raster
    // position, and queue the window mean when the pixel closes a window.
    // ------------------------------------------------------------------
    function automatic bit advance_window(input logic [PIXEL_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        int unsigned      p;
        int unsigned      win_len;
        int unsigned      wfull;
        int unsigned      hfull;
        int unsigned      slot;
        logic [SUM_W-1:0] sum;
        t_result          res;
        bit               made;

        made = 1'b0;
        res  = '0;
        w    = cur_width;
        h    = cur_height;
        p    = cur_power;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h == 0) h = 1;
        if (p > MAX_POWER) p = MAX_POWER;

        if (p == 0) begin
            res.average    = pix;
            res.frame_last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
            made           = 1'b1;
        end else begin
            win_len = 1 << p;
            wfull   = (w >> p) << p;
            hfull   = (h >> p) << p;
            // Pixels past the last whole window are swallowed.
            if (col_pos < wfull && row_pos < hfull) begin
                slot = (col_pos >> p) % SUM_ENTRIES;
                if (col_pos % win_len == 0 && row_pos % win_len == 0)
                    sum = SUM_W'(pix);
                else
                    sum = band_sums[slot] + SUM_W'(pix);
                if (col_pos % win_len == win_len - 1 && row_pos % win_len == win_len - 1) begin
                    res.average    = PIXEL_W'(sum >> (2 * p));
                    res.frame_last = (col_pos + 1 == wfull) && (row_pos + 1 == hfull);
                    made           = 1'b1;
                end
                band_sums[slot] = sum;
            end
        end

        if (made) pending_averages.push_back(res);

        // Advance the raster position; an oversized counter wraps here.
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        return made;
    endfunction

    function automatic logic [PIXEL_W-1:0] make_pixel();
        case (pixel_style)
            STYLE_WHITE:  return 8'hFF;
            STYLE_BLACK:  return 8'h00;
            STYLE_BRIGHT: return PIXEL_W'($urandom_range(240, 255));
            default:      return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Pixel sender: optional idle burst, then offer the pixel and hold it
    // until the transaction completes.
    // ------------------------------------------------------------------
    task automatic push_pixel(input logic [PIXEL_W-1:0] pix, output bit made);
        int unsigned gap;

        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (o_stall);
        sent_items++;
        made = advance_window(pix);
    endtask

    task automatic feed_pixels(input int unsigned count);
        bit made;

        repeat (count) push_pixel(make_pixel(), made);
    endtask

    // Finish the frame in progress so that the next setting starts on a
    // clean band.
    task automatic realign();
        bit made;

        while (col_pos != 0 || row_pos != 0) push_pixel(make_pixel(), made);
    endtask

    // Drop valid, wait for every queued mean and then for the pipeline to
    // empty of pixels that produce nothing.
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  cur_width  = data[WIDTH_REG_W-1:0];
            CFG_FRAME_HEIGHT: cur_height = data[HEIGHT_REG_W-1:0];
            CFG_DOWN_POWER:   cur_power  = data[POWER_REG_W-1:0];
            default: ;
        endcase
    endtask

    // One phase: realign, pick a geometry and a power, then stream whole
    // frames, or now and then a frame cut short.
    task automatic run_phase(input bit calm);
        int unsigned p;
        int unsigned win_len;
        int unsigned mult_max;
        int unsigned h_mult;
        int unsigned w;
        int unsigned h;
        int unsigned frames;
        int unsigned count;

        realign();
        p        = $urandom_range(0, MAX_POWER);
        win_len  = 1 << p;
        mult_max = (p == 0) ? 8 : ((p == 1) ? 4 : 2);
        h_mult   = (p == MAX_POWER) ? 1 : mult_max;
        case ($urandom_range(0, 9))
            0:       w = 0;
            1, 2:    w = win_len * $urandom_range(1, mult_max) + $urandom_range(0, win_len - 1);
            default: w = win_len * $urandom_range(1, mult_max);
        endcase
        case ($urandom_range(0, 9))
            0:       h = 0;
            1, 2:    h = win_len * $urandom_range(1, h_mult) + $urandom_range(0, win_len - 1);
            default: h = win_len * $urandom_range(1, h_mult);
        endcase

        // Spare data bits above the power and width registers are ignored; toggle them too.
        write_reg(CFG_DOWN_POWER, {10'($urandom), 2'(p)});
        write_reg(CFG_FRAME_WIDTH, {1'($urandom), 11'(w)});
        write_reg(CFG_FRAME_HEIGHT, 12'(h));

        if (calm) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end else begin
            case ($urandom_range(0, 3))
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 5;
                2:       tx_idle_pct = 15;
                default: tx_idle_pct = 40;
            endcase
            case ($urandom_range(0, 3))
                0:       rx_idle_pct = 0;
                1:       rx_idle_pct = 5;
                2:       rx_idle_pct = 15;
                default: rx_idle_pct = 40;
            endcase
        end
        pixel_style = t_pixel_style'($urandom_range(0, 5) > 3 ? STYLE_UNIFORM
                                                             : $urandom_range(0, 3));

        if (w == 0) w = 1;
        if (h == 0) h = 1;
        frames = $urandom_range(1, (p < 2) ? 2 : 1);
        count  = w * h * frames;
        // Break the frame off part-way now and then.
        if (count > 1 && $urandom_range(0, 5) == 0) count = $urandom_range(1, count - 1);
        feed_pixels(count);
    endtask

    // ------------------------------------------------------------------
    // Downstream stall: random bursts, plus one long hold-off on request
    // so that the result queue fills and the block stalls its input.
    // ------------------------------------------------------------------
    initial begin : downstream_stall
        int unsigned burst;

        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            burst = 0;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                burst        = HOLD_OFF_CYCLES;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                burst = $urandom_range(1, 18);
            end
            if (burst != 0) begin
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted transaction with the oldest
    // queued mean, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result want;

        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_averages.size() == 0) begin
                $display("%0t: unexpected result average %02h frame_last %0b",
                         $time, o_average, o_frame_last);
                error_count++;
            end else begin
                want = pending_averages.pop_front();
                if (o_average !== want.average) begin
                    $display("%0t: average expected %02h, actual %02h",
                             $time, want.average, o_average);
                    error_count++;
                end
                if (o_frame_last !== want.frame_last) begin
                    $display("%0t: frame_last expected %0b, actual %0b",
                             $time, want.frame_last, o_frame_last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("** box_average_downsampler: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin : stimulus
        bit made;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A typed row overrides the predicted mean.
        foreach (directed_steps[k]) begin
            if (directed_steps[k].kind == STEP_WRITE) begin
                write_reg(directed_steps[k].reg_index, directed_steps[k].reg_data);
            end else begin
                push_pixel(directed_steps[k].pixel, made);
                if (directed_steps[k].typed) begin
                    if (made) void'(pending_averages.pop_back());
                    pending_averages.push_back(directed_steps[k].want);
                end
            end
        end

        // Random part: whole frames with random content, some cut short.
        while (sent_items < RANDOM_END)
            run_phase(1'b0);

        // Extremes of the registers.
        realign();
        pixel_style = STYLE_UNIFORM;
        // Width above the limit saturates; one full-width row.
        write_reg(CFG_DOWN_POWER, 12'd0);
        write_reg(CFG_FRAME_HEIGHT, 12'd1);
        write_reg(CFG_FRAME_WIDTH, 12'hFFF);
        feed_pixels(MAX_WIDTH);
        // Largest window, saturated and empty sums.
        write_reg(CFG_FRAME_WIDTH, 12'd8);
        write_reg(CFG_FRAME_HEIGHT, 12'd8);
        write_reg(CFG_DOWN_POWER, 12'hFFF);
        pixel_style = STYLE_WHITE;
        feed_pixels(64);
        pixel_style = STYLE_BLACK;
        feed_pixels(64);
        // Tallest frame, then cut it down mid-frame so the row count wraps.
        pixel_style = STYLE_UNIFORM;
        write_reg(CFG_DOWN_POWER, 12'd0);
        write_reg(CFG_FRAME_WIDTH, 12'd3);
        write_reg(CFG_FRAME_HEIGHT, 12'hFFF);
        feed_pixels(40);
        write_reg(CFG_FRAME_HEIGHT, 12'd5);
        realign();
        // A write to the spare index must leave every register alone.
        write_reg(CFG_UNUSED, 12'($urandom));
        feed_pixels(15);
        realign();

        // Back-pressure: hold the output off while pixels keep coming.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(CFG_FRAME_WIDTH, 12'd16);
        write_reg(CFG_FRAME_HEIGHT, 12'd4);
        hold_off_req = 1'b1;
        feed_pixels(64);

        // Closing stretch with no idling on either side.
        do
            run_phase(1'b1);
        while (sent_items < TOTAL_ITEMS);

        i_valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("** box_average_downsampler: PASSED **");
        else
            $display("** box_average_downsampler: FAILED **");
        $finish;
    end

endmodule

### sim.f
rtl/boxds_pkg.sv
rtl/boxds_out_queue.sv
rtl/box_average_downsampler.sv
dv/tb.sv
